// File: hdl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and codes for the strict priority multi-queue scheduler.
// ----------------------------------------------------------------------------
package spmq_pkg;

	// Action codes carried by an input transaction
	localparam logic ACT_ENQUEUE  = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	// Status codes carried by a result transaction
	localparam logic [1:0] ST_ENQUEUED   = 2'd0;
	localparam logic [1:0] ST_DISPATCHED = 2'd1;
	localparam logic [1:0] ST_EMPTY      = 2'd2;

	typedef struct packed {
		logic       action;
		logic [7:0] job_id;
		logic [1:0] job_level;
	} spmq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_job;
		logic [1:0] out_level;
	} spmq_out_t;

	// Control sequencer states
	typedef enum logic {
		S_IDLE,
		S_LINK
	} spmq_state_t;

endpackage

// File: hdl/spmq_link_mem.sv
// ----------------------------------------------------------------------------
// spmq_link_mem
// Next-link table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spmq_link_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write the link entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the link entry into the registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/strict_priority_multi_queue.sv
// Enqueue, nothing-ready and last-job dispatch results appear in the cycle after accept.
// A dispatch that leaves jobs behind shows its result after passing through S_LINK.
// Throughput: one transaction per cycle while the result slot is free or drained; in S_LINK
// none is taken while a dispatch fetches the next level head from the link memory read port.
// Reset clears the occupied flags and the sequencer; the link memory needs no clearing pass.
// Head, tail and link entries hold no reset value and are written before being read.
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// One linked FIFO per priority level over a shared next-link memory. Enqueue
// appends to the tail of a level; dispatch pops the head of the highest
// occupied level.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue
	import spmq_pkg::*;
#(
	parameter int LEVELS  = 4,
	parameter int JOB_IDS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  spmq_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output spmq_out_t out_data
);

	localparam int IW = $clog2(JOB_IDS);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// Reduce a raw id modulo JOB_IDS by restoring subtraction
	function automatic logic [IW-1:0] fold_id(input logic [7:0] raw);
		logic [31:0] r;
		r = {24'd0, raw};
		if (JOB_IDS < 256) begin
			for (int k = 7; k >= 0; k--) begin
				if (r >= (32'(JOB_IDS) << k)) begin
					r = r - (32'(JOB_IDS) << k);
				end
			end
		end
		return IW'(r);
	endfunction

	spmq_state_t state_q, state_d;

	logic [LEVELS-1:0] occ_q;
	logic [IW-1:0]     head_q [LEVELS];
	logic [IW-1:0]     tail_q [LEVELS];
	logic              out_valid_q;
	spmq_out_t         out_data_q;
	logic [LW-1:0]     lvl_s1;
	logic [IW-1:0]     job_s1;

	logic          acc;
	logic          is_disp;
	logic [IW-1:0] enq_id;
	logic [LW-1:0] enq_lvl;
	logic [LW-1:0] hi_lvl;
	logic          any_occ;
	logic [LW-1:0] sel_lvl;
	logic [IW-1:0] head_sel;
	logic [IW-1:0] tail_sel;
	logic          occ_sel;
	logic          need_link;
	logic          last_job;
	logic          link_we;
	logic [IW-1:0] link_rdata;

	// Decode the incoming transaction
	always_comb begin
		acc     = in_valid && in_ready;
		is_disp = (in_data.action == ACT_DISPATCH);
		enq_id  = fold_id(in_data.job_id);
		if (32'(in_data.job_level) >= LEVELS) begin
			enq_lvl = LW'(LEVELS - 1);
		end else begin
			enq_lvl = LW'(in_data.job_level);
		end
	end

	// Find the highest occupied level
	always_comb begin
		hi_lvl  = '0;
		any_occ = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (occ_q[i]) begin
				hi_lvl  = LW'(i);
				any_occ = 1'b1;
			end
		end
	end

	// Select the level touched by this transaction
	always_comb begin
		sel_lvl   = is_disp ? hi_lvl : enq_lvl;
		head_sel  = head_q[sel_lvl];
		tail_sel  = tail_q[sel_lvl];
		occ_sel   = occ_q[sel_lvl];
		last_job  = (head_sel == tail_sel);
		need_link = acc && is_disp && any_occ && !last_job;
		link_we   = acc && !is_disp && occ_sel;
	end

	spmq_link_mem #(
		.DEPTH (JOB_IDS),
		.WIDTH (IW)
	) u_link_mem (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (tail_sel),
		.wr_data (enq_id),
		.rd_en   (need_link),
		.rd_addr (head_sel),
		.rd_data (link_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (need_link) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		unique case (state_q)
			S_IDLE:  in_ready = !out_valid_q || out_ready;
			S_LINK:  in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	// Advance control state: sequencer, occupied flags, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (!is_disp) begin
					occ_q[sel_lvl] <= 1'b1;
				end else if (any_occ && last_job) begin
					occ_q[sel_lvl] <= 1'b0;
				end
			end
			if ((acc && !need_link) || (state_q == S_LINK)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Update heads, tails, pending dispatch and the result register
	always_ff @(posedge clk) begin
		if (acc && !is_disp) begin
			if (!occ_sel) begin
				head_q[sel_lvl] <= enq_id;
			end
			tail_q[sel_lvl] <= enq_id;
		end
		if (need_link) begin
			lvl_s1 <= sel_lvl;
			job_s1 <= head_sel;
		end
		if (state_q == S_LINK) begin
			head_q[lvl_s1] <= link_rdata;
			out_data_q.status    <= ST_DISPATCHED;
			out_data_q.out_job   <= 8'(job_s1);
			out_data_q.out_level <= 2'(lvl_s1);
		end else if (acc && !need_link) begin
			if (!is_disp) begin
				out_data_q.status    <= ST_ENQUEUED;
				out_data_q.out_job   <= '0;
				out_data_q.out_level <= '0;
			end else if (any_occ) begin
				out_data_q.status    <= ST_DISPATCHED;
				out_data_q.out_job   <= 8'(head_sel);
				out_data_q.out_level <= 2'(sel_lvl);
			end else begin
				out_data_q.status    <= ST_EMPTY;
				out_data_q.out_job   <= '0;
				out_data_q.out_level <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The result slot is free while the link read is in flight
	a_link_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |-> !out_valid_q)
		else $error("result slot busy during link fetch");

	// A pending dispatch still owns an occupied level
	a_link_level_occ: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |-> occ_q[lvl_s1])
		else $error("link fetch for an empty level");

	// The link fetch always ends in a dispatched result
	a_link_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |=> out_valid_q && out_data_q.status == ST_DISPATCHED)
		else $error("link fetch did not produce a dispatch result");

	// Link writes and link reads never share a cycle
	a_link_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(link_we && need_link))
		else $error("link write and read in the same cycle");

endmodule
